### hdl/bracket_balance_checker_defines.svh
// Assertion macros shared by the bracket balance checker modules.
// No dependencies; included by the files that carry concurrent assertions.
`ifndef BRACKET_BALANCE_CHECKER_DEFINES_SVH
`define BRACKET_BALANCE_CHECKER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define BBC_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define BBC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/bbc_pkg.sv
// Shared types and constants for the bracket balance checker.
// No dependencies; used by every module of the block.
`default_nettype none

package bbc_pkg;

    localparam int DEFAULT_STACK_DEPTH = 256;
    localparam int CHAR_W              = 8;
    localparam int COUNT_W             = 16;
    localparam int KIND_W              = 2;
    localparam int S_TDATA_W           = 8;
    localparam int M_TDATA_W           = 24;
    localparam int QUEUE_DEPTH         = 4;

    localparam logic [CHAR_W-1:0] CH_OPEN_ROUND   = 8'h28;
    localparam logic [CHAR_W-1:0] CH_CLOSE_ROUND  = 8'h29;
    localparam logic [CHAR_W-1:0] CH_OPEN_CURLY   = 8'h7B;
    localparam logic [CHAR_W-1:0] CH_CLOSE_CURLY  = 8'h7D;
    localparam logic [CHAR_W-1:0] CH_OPEN_SQUARE  = 8'h5B;
    localparam logic [CHAR_W-1:0] CH_CLOSE_SQUARE = 8'h5D;

    localparam logic [KIND_W-1:0] KIND_ROUND  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_CURLY  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_SQUARE = 2'd2;
    localparam logic [KIND_W-1:0] KIND_NONE   = 2'd3;

    // One classified word handed from the front end to the stack engine.
    typedef struct packed {
        logic              is_open;
        logic              is_close;
        logic [KIND_W-1:0] kind;
        logic              last;
    } bbc_op_t;

endpackage

`default_nettype wire

### hdl/bbc_front.sv
// Front end: classifies each input byte into a stack operation.
// Depends on bbc_pkg; feeds bbc_queue.
`default_nettype none

module bbc_front (
    input  wire logic                      in_valid,
    output logic                           in_ready,
    input  wire logic [bbc_pkg::CHAR_W-1:0] in_char,
    input  wire logic                      in_last,
    input  wire logic                      q_ready,
    output logic                           q_push,
    output bbc_pkg::bbc_op_t               q_op
);

    always_comb begin
        q_op.is_open  = 1'b0;
        q_op.is_close = 1'b0;
        q_op.kind     = bbc_pkg::KIND_NONE;
        q_op.last     = in_last;
        unique case (in_char)
            bbc_pkg::CH_OPEN_ROUND: begin
                q_op.is_open = 1'b1;
                q_op.kind    = bbc_pkg::KIND_ROUND;
            end
            bbc_pkg::CH_OPEN_CURLY: begin
                q_op.is_open = 1'b1;
                q_op.kind    = bbc_pkg::KIND_CURLY;
            end
            bbc_pkg::CH_OPEN_SQUARE: begin
                q_op.is_open = 1'b1;
                q_op.kind    = bbc_pkg::KIND_SQUARE;
            end
            bbc_pkg::CH_CLOSE_ROUND: begin
                q_op.is_close = 1'b1;
                q_op.kind     = bbc_pkg::KIND_ROUND;
            end
            bbc_pkg::CH_CLOSE_CURLY: begin
                q_op.is_close = 1'b1;
                q_op.kind     = bbc_pkg::KIND_CURLY;
            end
            bbc_pkg::CH_CLOSE_SQUARE: begin
                q_op.is_close = 1'b1;
                q_op.kind     = bbc_pkg::KIND_SQUARE;
            end
            default: begin
                q_op.kind = bbc_pkg::KIND_NONE;
            end
        endcase
    end

    // Drop plain bytes; only brackets and end-of-string marks reach the queue.
    assign in_ready = q_ready;
    assign q_push   = in_valid && q_ready && (q_op.is_open || q_op.is_close || q_op.last);

endmodule

`default_nettype wire

### hdl/bbc_queue.sv
// Short FIFO of classified operations between front end and stack engine.
// Depends on bbc_pkg and the assertion macro header.
`default_nettype none
`include "bracket_balance_checker_defines.svh"

module bbc_queue (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             push,
    input  wire bbc_pkg::bbc_op_t push_op,
    output logic                  push_ready,
    output logic                  pop_valid,
    output bbc_pkg::bbc_op_t      pop_op,
    input  wire logic             pop_ready
);

    localparam int PW = $clog2(bbc_pkg::QUEUE_DEPTH);
    localparam int CW = $clog2(bbc_pkg::QUEUE_DEPTH + 1);

    bbc_pkg::bbc_op_t entry_reg [bbc_pkg::QUEUE_DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          pop;

    assign push_ready = (cnt_reg != CW'(bbc_pkg::QUEUE_DEPTH));
    assign pop_valid  = (cnt_reg != '0);
    assign pop_op     = entry_reg[rd_ptr_reg];
    assign pop        = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + PW'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + PW'(1) : rd_ptr_reg;
        cnt_next    = cnt_reg + CW'(push) - CW'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_op;
        end
    end

    `BBC_ASSERT_NOW(a_q_no_overfill, aclk, aresetn, push, cnt_reg != CW'(bbc_pkg::QUEUE_DEPTH), "queue written while full")
    `BBC_ASSERT_NEXT(a_q_fill_grows, aclk, aresetn, push && !pop, cnt_reg == $past(cnt_reg) + CW'(1), "queue fill did not advance")

endmodule

`default_nettype wire

### hdl/bbc_back.sv
// Stack engine: applies push/pop operations, keeps flags and count,
// and holds the per-string result in an output register. Depends on bbc_pkg.
`default_nettype none
`include "bracket_balance_checker_defines.svh"

module bbc_back #(
    parameter int STACK_DEPTH = bbc_pkg::DEFAULT_STACK_DEPTH
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        op_valid,
    input  wire bbc_pkg::bbc_op_t            op,
    output logic                             op_ready,
    output logic                             res_valid,
    input  wire logic                        res_ready,
    output logic                             res_balanced,
    output logic [bbc_pkg::COUNT_W-1:0]      res_count,
    output logic                             res_overflowed
);

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int DW = $clog2(STACK_DEPTH + 1);
    localparam int KW = bbc_pkg::KIND_W;
    localparam int NW = bbc_pkg::COUNT_W;

    // Entries below depth-2 live in memory; the top two sit in registers.
    logic [KW-1:0] stack_mem [STACK_DEPTH];
    logic [KW-1:0] rd_data_reg;
    logic [KW-1:0] fwd_data_reg;
    logic          fwd_hit_reg;
    logic [KW-1:0] stack_q;

    logic [DW-1:0] depth_reg, depth_next;
    logic [KW-1:0] top_reg, top_next;
    logic [KW-1:0] sec_reg, sec_next;
    logic          mis_reg, mis_next;
    logic          ovf_reg, ovf_next;
    logic [NW-1:0] cnt_reg, cnt_next;

    logic          out_valid_reg, out_valid_next;
    logic          out_bal_reg, out_bal_next;
    logic [NW-1:0] out_cnt_reg, out_cnt_next;
    logic          out_ovf_reg, out_ovf_next;

    logic          op_fire;
    logic          mem_we;
    logic [DW-1:0] depth_m2, raddr_full;
    logic [AW-1:0] waddr, raddr;

    assign op_ready = !out_valid_reg || res_ready || !op.last;
    assign op_fire  = op_valid && op_ready;
    assign stack_q  = fwd_hit_reg ? fwd_data_reg : rd_data_reg;
    assign depth_m2 = depth_reg - DW'(2);
    assign waddr    = depth_m2[AW-1:0];
    assign raddr_full = depth_next - DW'(3);
    assign raddr    = raddr_full[AW-1:0];

    always_comb begin
        depth_next     = depth_reg;
        top_next       = top_reg;
        sec_next       = sec_reg;
        mis_next       = mis_reg;
        ovf_next       = ovf_reg;
        cnt_next       = cnt_reg;
        mem_we         = 1'b0;
        out_valid_next = out_valid_reg && !res_ready;
        out_bal_next   = out_bal_reg;
        out_cnt_next   = out_cnt_reg;
        out_ovf_next   = out_ovf_reg;
        if (op_fire) begin
            if ((op.is_open || op.is_close) && (cnt_reg != '1)) begin
                cnt_next = cnt_reg + NW'(1);
            end
            if (op.is_open) begin
                if (depth_reg == DW'(STACK_DEPTH)) begin
                    ovf_next = 1'b1;
                end else begin
                    depth_next = depth_reg + DW'(1);
                    top_next   = op.kind;
                    sec_next   = top_reg;
                    mem_we     = (depth_reg >= DW'(2));
                end
            end else if (op.is_close) begin
                if (depth_reg == '0) begin
                    mis_next = 1'b1;
                end else if (top_reg == op.kind) begin
                    depth_next = depth_reg - DW'(1);
                    top_next   = sec_reg;
                    sec_next   = stack_q;
                end else begin
                    mis_next = 1'b1;
                end
            end
            if (op.last) begin
                out_valid_next = 1'b1;
                out_bal_next   = !mis_next && !ovf_next && (depth_next == '0);
                out_cnt_next   = cnt_next;
                out_ovf_next   = ovf_next;
                depth_next     = '0;
                mis_next       = 1'b0;
                ovf_next       = 1'b0;
                cnt_next       = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            depth_reg     <= '0;
            mis_reg       <= 1'b0;
            ovf_reg       <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            depth_reg     <= depth_next;
            mis_reg       <= mis_next;
            ovf_reg       <= ovf_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        top_reg     <= top_next;
        sec_reg     <= sec_next;
        out_bal_reg <= out_bal_next;
        out_cnt_reg <= out_cnt_next;
        out_ovf_reg <= out_ovf_next;
    end

    // Prefetch the entry under the top two so that a pop can refill the second register from it.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            stack_mem[waddr] <= sec_reg;
        end
        rd_data_reg  <= stack_mem[raddr];
        fwd_hit_reg  <= mem_we && (waddr == raddr);
        fwd_data_reg <= sec_reg;
    end

    assign res_valid      = out_valid_reg;
    assign res_balanced   = out_bal_reg;
    assign res_count      = out_cnt_reg;
    assign res_overflowed = out_ovf_reg;

    `BBC_ASSERT_NOW(a_depth_range, aclk, aresetn, 1'b1, depth_reg <= DW'(STACK_DEPTH), "stack depth out of range")
    `BBC_ASSERT_NEXT(a_last_clears, aclk, aresetn, op_fire && op.last, out_valid_reg && (depth_reg == '0) && !mis_reg && !ovf_reg && (cnt_reg == '0), "string end did not clear state")
    `BBC_ASSERT_NEXT(a_empty_close, aclk, aresetn, op_fire && op.is_close && !op.last && (depth_reg == '0), mis_reg && (depth_reg == '0), "closer on empty stack not flagged")

endmodule

`default_nettype wire

### hdl/bracket_balance_checker.sv
// Top level of the bracket balance checker: front end, operation queue and
// stack engine. Depends on bbc_pkg, bbc_front, bbc_queue and bbc_back.
//
// Usage:
//   Input stream (s_*): one byte of a string per word in s_tdata[7:0];
//   s_tlast marks the final byte. Bytes other than ( ) { } [ ] are dropped
//   at the front end and never reach the stack.
//   Result stream (m_*): one word per string, issued for the word that
//   carried s_tlast: balanced, bracket count (saturating at 65535) and the
//   overflow flag. A string that overflowed the stack is never balanced.
//   Throughput: while results are taken, one input word per cycle, sustained, also
//   across string boundaries; the stack engine retires one queued operation per cycle,
//   since the top two stack entries are held in registers and the next one
//   is prefetched from the stack memory every cycle.
//   Result path: the last byte is written into the queue, and once it reaches the stack
//   engine the result is registered in the output register that drives m_tvalid.
//   Stall: when m_tready is low the result waits in the output register;
//   the engine keeps working on the next string until it reaches that
//   string's last byte, then the four-entry queue fills and s_tready drops.
//   Reset: aresetn low for one clock clears depth, flags, count, queue and
//   output valid; the stack memory needs no clearing pass.
`default_nettype none

module bracket_balance_checker #(
    parameter int STACK_DEPTH = bbc_pkg::DEFAULT_STACK_DEPTH
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [bbc_pkg::S_TDATA_W-1:0]   s_tdata,   // [7:0] char_in
    input  wire logic                            s_tlast,   // last
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [bbc_pkg::M_TDATA_W-1:0]        m_tdata    // [0] balanced,
                                                            // [16:1] bracket_count,
                                                            // [17] overflowed, rest zero
);

    localparam int NW  = bbc_pkg::COUNT_W;
    localparam int PAD = bbc_pkg::M_TDATA_W - NW - 2;

    bbc_pkg::bbc_op_t front_op;
    bbc_pkg::bbc_op_t back_op;
    logic             q_push;
    logic             q_ready;
    logic             q_valid;
    logic             back_ready;
    logic             res_balanced;
    logic [NW-1:0]    res_count;
    logic             res_overflowed;

    // Classify each byte; hold s_tready to queue space.
    bbc_front u_front (
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_char  (s_tdata[bbc_pkg::CHAR_W-1:0]),
        .in_last  (s_tlast),
        .q_ready  (q_ready),
        .q_push   (q_push),
        .q_op     (front_op)
    );

    // Decouple intake from the stack engine.
    bbc_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_op    (front_op),
        .push_ready (q_ready),
        .pop_valid  (q_valid),
        .pop_op     (back_op),
        .pop_ready  (back_ready)
    );

    // Run the stack and hold each string's result until taken.
    bbc_back #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .op_valid       (q_valid),
        .op             (back_op),
        .op_ready       (back_ready),
        .res_valid      (m_tvalid),
        .res_ready      (m_tready),
        .res_balanced   (res_balanced),
        .res_count      (res_count),
        .res_overflowed (res_overflowed)
    );

    assign m_tdata = {{PAD{1'b0}}, res_overflowed, res_count, res_balanced};

endmodule

`default_nettype wire
